/* rtl/vkal_pkg.sv */
package vkal_pkg;

  typedef enum logic [3:0] {
    FuncInsHead   = 4'd0,
    FuncFind      = 4'd1,
    FuncInsBefore = 4'd2,
    FuncInsAfter  = 4'd3,
    FuncReplace   = 4'd4,
    FuncErase     = 4'd5,
    FuncDump      = 4'd6,
    FuncNext      = 4'd7,
    FuncPrev      = 4'd8
  } func_e;

  typedef enum logic [1:0] {
    StDone = 2'd0,
    StData = 2'd1,
    StFail = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic        last;
  } result_t;

endpackage

/* rtl/vkal_mem.sv */
// Single-port-write, single-port-read memory with a registered read.
module vkal_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/value_keyed_array_list.sv */
// Ordered list of up to DEPTH signed 32-bit values kept packed in one
// synchronous memory and addressed by value: every search scans from the
// head and the first match decides. One request is handled at a time by a
// sequencer that walks the memory through its single read port. A request
// that fails or finishes at once (full list, empty dump, unknown function)
// goes straight to its result; a find, replace or prev ends at the first
// match, or at the end of the list when the key is missing, and next then
// fetches the neighbor. Inserts shift the entries at and above pos up to
// open the gap at pos, and an erase moves the entries after the match down.
// A dump delivers its elements in order, one result per element, while the
// output is taken. The next request is accepted at the earliest on the edge
// that hands over the final result. Data read from positions at or above
// count is never used.
module value_keyed_array_list #(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  func_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic signed [31:0] data_o,
  output logic        last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    SIdle, SScan, SShiftUp, SShiftDn, SDump, SOut
  } state_e;

  state_e state_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] idx_q;      // next index to read
  logic          rvalid_q;   // rdata holds a requested entry
  logic [CW-1:0] ridx_q;     // index of entry on rdata
  logic [CW-1:0] pos_q;      // target position for inserts
  logic [3:0]    func_q;
  logic [31:0]   key_q, value_q, prev_q;
  logic          have_prev_q;
  logic          found_q;
  vkal_pkg::result_t res_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  vkal_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign in_ready_o  = (state_q == SIdle) && (!out_valid_o || out_ready_i);
  assign status_o    = res_q.status;
  assign data_o      = res_q.data;
  assign last_o      = res_q.last;

  logic out_free;
  assign out_free = !out_valid_o || out_ready_i;

  // A result is presented from the output state or from a dump read.
  logic out_set;
  assign out_set = out_free && ((state_q == SOut) || ((state_q == SDump) && rvalid_q));

  logic match;
  assign match = rvalid_q && (rdata == key_q);

  // Memory address and write drive, decided from the current state.
  always_comb begin
    we    = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = rdata;
    raddr = idx_q[AW-1:0];
    unique case (state_q)
      SScan: begin
        // Replace writes the new value over the first match.
        if (match && (func_q == vkal_pkg::FuncReplace)) begin
          we    = 1'b1;
          waddr = ridx_q[AW-1:0];
          wdata = value_q;
        end
      end
      SShiftUp: begin
        // Read idx-1 and write it to idx once it arrives; the new value
        // goes into the opened slot after the last move.
        if (rvalid_q) begin
          we    = 1'b1;
          waddr = AW'(ridx_q + CW'(1));
        end else if (idx_q == pos_q) begin
          we    = 1'b1;
          waddr = pos_q[AW-1:0];
          wdata = value_q;
        end
        raddr = AW'(idx_q - CW'(1));
      end
      SShiftDn: begin
        if (rvalid_q) begin
          we    = 1'b1;
          waddr = AW'(ridx_q - CW'(1));
        end
      end
      SDump: begin
        // Keep reading the same entry while the output is busy.
        if (rvalid_q) begin
          raddr = ridx_q[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      out_valid_o <= 1'b0;
      idx_q       <= '0;
      rvalid_q    <= 1'b0;
      ridx_q      <= '0;
      pos_q       <= '0;
      func_q      <= '0;
      key_q       <= '0;
      value_q     <= '0;
      prev_q      <= '0;
      found_q     <= 1'b0;
      have_prev_q <= 1'b0;
      res_q       <= '0;
    end else begin
      out_valid_o <= out_set || (out_valid_o && !out_ready_i);
      unique case (state_q)
        SIdle: begin
          rvalid_q <= 1'b0;
          if (in_valid_i && in_ready_o) begin
            func_q      <= func_i;
            key_q       <= key_i;
            value_q     <= value_i;
            have_prev_q <= 1'b0;
            found_q     <= 1'b0;
            idx_q       <= (func_i == vkal_pkg::FuncInsHead) ? count_q : '0;
            unique case (func_i)
              vkal_pkg::FuncInsHead: begin
                if (count_q >= CW'(DEPTH)) begin
                  res_q <= '{vkal_pkg::StFail, 32'd0, 1'b1};
                  state_q <= SOut;
                end else begin
                  pos_q <= '0;
                  state_q <= SShiftUp;
                end
              end
              vkal_pkg::FuncInsBefore, vkal_pkg::FuncInsAfter: begin
                if (count_q >= CW'(DEPTH)) begin
                  res_q <= '{vkal_pkg::StFail, 32'd0, 1'b1};
                  state_q <= SOut;
                end else state_q <= SScan;
              end
              vkal_pkg::FuncFind, vkal_pkg::FuncReplace, vkal_pkg::FuncErase,
              vkal_pkg::FuncNext, vkal_pkg::FuncPrev: state_q <= SScan;
              vkal_pkg::FuncDump: begin
                if (count_q == '0) begin
                  res_q <= '{vkal_pkg::StDone, 32'd0, 1'b1};
                  state_q <= SOut;
                end else state_q <= SDump;
              end
              default: begin
                res_q <= '{vkal_pkg::StFail, 32'd0, 1'b1};
                state_q <= SOut;
              end
            endcase
          end
        end

        SScan: begin
          // Issue reads at idx_q; rdata holds entry ridx_q.
          if (found_q) begin
            // For next: the entry after the match has now arrived.
            rvalid_q <= 1'b0;
            res_q <= '{vkal_pkg::StData, rdata, 1'b1};
            state_q <= SOut;
          end else if (match) begin
            rvalid_q <= 1'b0;
            unique case (func_q)
              vkal_pkg::FuncFind: begin
                res_q <= '{vkal_pkg::StData, key_q, 1'b1};
                state_q <= SOut;
              end
              vkal_pkg::FuncReplace: begin
                res_q <= '{vkal_pkg::StDone, 32'd0, 1'b1};
                state_q <= SOut;
              end
              vkal_pkg::FuncPrev: begin
                res_q <= have_prev_q ? vkal_pkg::result_t'{vkal_pkg::StData, prev_q, 1'b1}
                                     : vkal_pkg::result_t'{vkal_pkg::StFail, 32'd0, 1'b1};
                state_q <= SOut;
              end
              vkal_pkg::FuncNext: begin
                if (ridx_q + CW'(1) >= count_q) begin
                  res_q <= '{vkal_pkg::StFail, 32'd0, 1'b1};
                  state_q <= SOut;
                end else begin
                  found_q  <= 1'b1;
                  idx_q    <= ridx_q + CW'(1);
                end
              end
              vkal_pkg::FuncErase: begin
                idx_q   <= ridx_q + CW'(1);
                state_q <= SShiftDn;
              end
              default: begin
                // Inserts before or after the match.
                pos_q   <= ridx_q + ((func_q == vkal_pkg::FuncInsAfter) ? CW'(1) : CW'(0));
                idx_q   <= count_q;
                state_q <= SShiftUp;
              end
            endcase
          end else if (rvalid_q && ridx_q + CW'(1) >= count_q || count_q == '0) begin
            rvalid_q <= 1'b0;
            res_q <= '{vkal_pkg::StFail, 32'd0, 1'b1};
            state_q <= SOut;
          end else begin
            if (rvalid_q) begin
              prev_q      <= rdata;
              have_prev_q <= 1'b1;
            end
            if (idx_q < count_q) begin
              rvalid_q <= 1'b1;
              ridx_q   <= idx_q;
              idx_q    <= idx_q + CW'(1);
            end else rvalid_q <= 1'b0;
          end
        end

        SShiftUp: begin
          // Move entries [pos, count) up by one, top first, then write the
          // new value at pos.
          if (idx_q > pos_q) begin
            rvalid_q <= 1'b1;
            ridx_q   <= idx_q - CW'(1);
            idx_q    <= idx_q - CW'(1);
          end else if (rvalid_q) begin
            rvalid_q <= 1'b0;
          end else begin
            state_q  <= SOut;
            count_q  <= count_q + CW'(1);
            res_q    <= '{vkal_pkg::StDone, 32'd0, 1'b1};
          end
        end

        SShiftDn: begin
          // Move entries (m, count) down by one.
          if (idx_q < count_q) begin
            rvalid_q <= 1'b1;
            ridx_q   <= idx_q;
            idx_q    <= idx_q + CW'(1);
          end else if (rvalid_q) begin
            rvalid_q <= 1'b0;
          end else begin
            state_q <= SOut;
            count_q <= count_q - CW'(1);
            res_q   <= '{vkal_pkg::StDone, 32'd0, 1'b1};
          end
        end

        SDump: begin
          // Alternate between reading an element and handing it out, holding when the output is busy.
          if (rvalid_q) begin
            if (out_free) begin
              res_q <= '{vkal_pkg::StData, rdata,
                         (ridx_q + CW'(1) == count_q)};
              rvalid_q <= 1'b0;
              if (ridx_q + CW'(1) == count_q) state_q <= SIdle;
            end
          end else begin
            rvalid_q <= 1'b1;
            ridx_q   <= idx_q;
            idx_q    <= idx_q + CW'(1);
          end
        end

        SOut: begin
          if (out_free) begin
            state_q     <= SIdle;
          end
        end

        default: state_q <= SIdle;
      endcase
    end
  end

endmodule
